@@ design/segment_segment_contact_test_defines.svh @@
// Assertion macros used by the segment contact test checker
`ifndef SEGMENT_SEGMENT_CONTACT_TEST_DEFINES_SVH
`define SEGMENT_SEGMENT_CONTACT_TEST_DEFINES_SVH

// Same-cycle implication, off during reset
`define SSTC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define SSTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset
`define SSTC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sstc_pkg.sv @@
// Shared constants for the segment contact test
package sstc_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int PARAM_BITS      = 24;
  localparam int LIMIT_W         = 32;
  localparam int MUL_LAT         = 2;
  localparam int EPS_DIVISOR     = 1000000;
  localparam int N_PTS           = 12;
endpackage

@@ design/sstc_in_if.sv @@
// Input channel: end points of two segments
interface sstc_in_if #(
  parameter int CW = sstc_pkg::COORD_WIDTH_DEF
);
  logic              valid;
  logic              ready;
  logic signed [CW-1:0] a_start_x, a_start_y, a_start_z;
  logic signed [CW-1:0] a_end_x, a_end_y, a_end_z;
  logic signed [CW-1:0] b_start_x, b_start_y, b_start_z;
  logic signed [CW-1:0] b_end_x, b_end_y, b_end_z;

  modport source (
    output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
           b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
           b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
    output ready
  );
endinterface

@@ design/sstc_out_if.sv @@
// Result channel: contact flag
interface sstc_out_if;
  logic valid;
  logic ready;
  logic contact;

  modport source (output valid, contact, input ready);
  modport sink (input valid, contact, output ready);
endinterface

@@ design/sstc_mul.sv @@
// Two-stage signed multiplier built from four half-width partial products
module sstc_mul #(
  parameter int AW = 34,
  parameter int BW = 34
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [AW-1:0]   a,
  input  logic signed [BW-1:0]   b,
  output logic signed [AW+BW-1:0] p
);
  localparam int HA = AW / 2;
  localparam int HB = BW / 2;
  localparam int RW = AW + BW;

  logic signed [HA:0]            al;
  logic signed [HB:0]            bl;
  logic signed [AW-HA-1:0]       ah;
  logic signed [BW-HB-1:0]       bh;
  logic signed [HA+HB+1:0]       ll_r;
  logic signed [HA+BW-HB:0]      lh_r;
  logic signed [AW-HA+HB:0]      hl_r;
  logic signed [RW-HA-HB-1:0]    hh_r;
  logic signed [RW-1:0]          sum_nxt;

  // split operands: low halves unsigned, high halves signed
  assign al = $signed({1'b0, a[HA-1:0]});
  assign bl = $signed({1'b0, b[HB-1:0]});
  assign ah = $signed(a[AW-1:HA]);
  assign bh = $signed(b[BW-1:HB]);

  // stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= al * bl;
      lh_r <= al * bh;
      hl_r <= ah * bl;
      hh_r <= ah * bh;
    end
  end

  // stage 2: align and add
  assign sum_nxt = (RW'(hh_r) <<< (HA + HB)) + (RW'(hl_r) <<< HA)
                 + (RW'(lh_r) <<< HB) + RW'(ll_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum_nxt;
    end
  end
endmodule

@@ design/sstc_dly.sv @@
// Valid and side data delay that matches the multiplier latency
module sstc_dly #(
  parameter int PLW   = 1,
  parameter int DEPTH = sstc_pkg::MUL_LAT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [PLW-1:0] pl_in,
  output logic           out_vld,
  output logic [PLW-1:0] pl_out
);
  logic           vld_r [DEPTH];
  logic [PLW-1:0] pl_r  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_tap
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else if (en) begin
          vld_r[i] <= in_vld;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          pl_r[i] <= pl_in;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else if (en) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          pl_r[i] <= pl_r[i-1];
        end
      end
    end
  end

  assign out_vld = vld_r[DEPTH-1];
  assign pl_out  = pl_r[DEPTH-1];
endmodule

@@ design/sstc_div.sv @@
// Pipelined clamped fraction divider: one restoring step per stage
module sstc_div #(
  parameter int W   = 64,
  parameter int QB  = sstc_pkg::PARAM_BITS,
  parameter int PLW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic signed [W-1:0] n,
  input  logic signed [W-1:0] d,
  input  logic [PLW-1:0]      pl_in,
  output logic                out_vld,
  output logic [QB:0]         q,
  output logic [PLW-1:0]      pl_out
);
  logic [W-1:0]   rem_r  [QB+1];
  logic [W-1:0]   den_r  [QB+1];
  logic [QB-1:0]  q_r    [QB+1];
  logic           zero_r [QB+1];
  logic           one_r  [QB+1];
  logic           vld_r  [QB+1];
  logic [PLW-1:0] pl_r   [QB+1];
  logic           zero_nxt;

  // quotient is 0 for a non-positive numerator or denominator
  assign zero_nxt = d[W-1] || (d == '0) || n[W-1] || (n == '0);

  // stage 0: classify and load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= n;
      den_r[0]  <= d;
      q_r[0]    <= '0;
      zero_r[0] <= zero_nxt;
      one_r[0]  <= !zero_nxt && (n >= d);
      pl_r[0]   <= pl_in;
    end
  end

  // one quotient bit per stage
  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [W-1:0] rem2;
    logic         ge;

    assign rem2 = {rem_r[i-1][W-2:0], 1'b0};
    assign ge   = rem2 >= den_r[i-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? (rem2 - den_r[i-1]) : rem2;
        den_r[i]  <= den_r[i-1];
        q_r[i]    <= {q_r[i-1][QB-2:0], ge};
        zero_r[i] <= zero_r[i-1];
        one_r[i]  <= one_r[i-1];
        pl_r[i]   <= pl_r[i-1];
      end
    end
  end

  // apply clamps
  always_comb begin
    if (zero_r[QB]) begin
      q = '0;
    end else if (one_r[QB]) begin
      q = {1'b1, {QB{1'b0}}};
    end else begin
      q = {1'b0, q_r[QB]};
    end
  end

  assign out_vld = vld_r[QB];
  assign pl_out  = pl_r[QB];
endmodule

@@ design/sstc_dots.sv @@
// Front end: segment vectors and the five dot products
module sstc_dots #(
  parameter int CW = sstc_pkg::COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_in,
  input  logic signed [CW-1:0]  pt [sstc_pkg::N_PTS],
  output logic                  vld_out,
  output logic signed [2*CW+3:0] a,
  output logic signed [2*CW+3:0] b,
  output logic signed [2*CW+3:0] c,
  output logic signed [2*CW+3:0] d,
  output logic signed [2*CW+3:0] e,
  output logic [2:0][CW:0]      u,
  output logic [2:0][CW:0]      v,
  output logic [2:0][CW:0]      w
);
  import sstc_pkg::*;

  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int DOTW = PW + 2;

  logic                 vld1_r, vld2_r, vld3_r;
  logic [2:0][DW-1:0]   u1_r, v1_r, w1_r, u2_r, v2_r, w2_r, u3_r, v3_r, w3_r;
  logic signed [PW-1:0] pa_r [3];
  logic signed [PW-1:0] pb_r [3];
  logic signed [PW-1:0] pc_r [3];
  logic signed [PW-1:0] pd_r [3];
  logic signed [PW-1:0] pe_r [3];
  logic signed [DOTW-1:0] a_r, b_r, c_r, d_r, e_r;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_in;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // stage 1: direction and offset vectors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u1_r[k] <= DW'(pt[3+k]) - DW'(pt[k]);
        v1_r[k] <= DW'(pt[9+k]) - DW'(pt[6+k]);
        w1_r[k] <= DW'(pt[k]) - DW'(pt[6+k]);
      end
    end
  end

  // stage 2: component products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pa_r[k] <= $signed(u1_r[k]) * $signed(u1_r[k]);
        pb_r[k] <= $signed(u1_r[k]) * $signed(v1_r[k]);
        pc_r[k] <= $signed(v1_r[k]) * $signed(v1_r[k]);
        pd_r[k] <= $signed(u1_r[k]) * $signed(w1_r[k]);
        pe_r[k] <= $signed(v1_r[k]) * $signed(w1_r[k]);
      end
      u2_r <= u1_r;
      v2_r <= v1_r;
      w2_r <= w1_r;
    end
  end

  // stage 3: sum the components
  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= DOTW'(pa_r[0]) + DOTW'(pa_r[1]) + DOTW'(pa_r[2]);
      b_r  <= DOTW'(pb_r[0]) + DOTW'(pb_r[1]) + DOTW'(pb_r[2]);
      c_r  <= DOTW'(pc_r[0]) + DOTW'(pc_r[1]) + DOTW'(pc_r[2]);
      d_r  <= DOTW'(pd_r[0]) + DOTW'(pd_r[1]) + DOTW'(pd_r[2]);
      e_r  <= DOTW'(pe_r[0]) + DOTW'(pe_r[1]) + DOTW'(pe_r[2]);
      u3_r <= u2_r;
      v3_r <= v2_r;
      w3_r <= w2_r;
    end
  end

  assign vld_out = vld3_r;
  assign a = a_r;
  assign b = b_r;
  assign c = c_r;
  assign d = d_r;
  assign e = e_r;
  assign u = u3_r;
  assign v = v3_r;
  assign w = w3_r;
endmodule

@@ design/segment_segment_contact_test.sv @@
// Segment-to-segment contact test, top level
// Takes one pair of 3D segments per clock and returns one contact flag per pair,
// in order. The flag is 1 when the squared distance between the closest points
// of the two segments is at most the limit written through cfg_wdata (Q0.32 at
// the default format). The pipeline is built from three 25-stage restoring
// divider pipelines (s, then t, then s again) plus the dot-product front end and
// the split wide multipliers. The whole pipeline holds while a finished flag
// waits on out_res, and otherwise takes a new pair each cycle. Write the limit
// only while no pair is in flight.
module segment_segment_contact_test #(
  parameter int COORD_WIDTH = sstc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sstc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sstc_in_if.sink                       in_seg,
  sstc_out_if.source                    out_res,
  input  logic                          cfg_we,
  input  logic [sstc_pkg::LIMIT_W-1:0]  cfg_wdata
);
  import sstc_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int DOTW = PW + 2;
  localparam int WPW  = 2 * DOTW;
  localparam int NW   = WPW + 1;
  localparam int PB   = PARAM_BITS;
  localparam int QW   = PB + 1;
  localparam int SW   = QW + 1;
  localparam int BSW  = DOTW + SW;
  localparam int TW   = BSW + 1;
  localparam int XW   = DW + SW + 2;
  localparam int SQW  = 2 * XW + 2;
  localparam int EPW  = (NW > 4 * FRAC_BITS + 2) ? NW : 4 * FRAC_BITS + 2;
  localparam logic [EPW-1:0] EPS = (EPW'(1) << (4 * FRAC_BITS)) / EPW'(EPS_DIVISOR);

  typedef struct packed {
    logic signed [DOTW-1:0] a;
    logic signed [DOTW-1:0] b;
    logic signed [DOTW-1:0] c;
    logic signed [DOTW-1:0] d;
    logic signed [DOTW-1:0] e;
    logic [2:0][DW-1:0]     u;
    logic [2:0][DW-1:0]     v;
    logic [2:0][DW-1:0]     w;
  } geo_t;

  typedef struct packed {
    logic signed [DOTW-1:0] a;
    logic signed [DOTW-1:0] b;
    logic signed [DOTW-1:0] d;
    logic [2:0][DW-1:0]     u;
    logic [2:0][DW-1:0]     v;
    logic [2:0][DW-1:0]     w;
  } tst_t;

  typedef struct packed {
    logic signed [DOTW-1:0] a;
    logic signed [DOTW-1:0] d;
    logic [2:0][DW-1:0]     u;
    logic [2:0][DW-1:0]     v;
    logic [2:0][DW-1:0]     w;
    logic [QW-1:0]          t;
  } fin_t;

  typedef struct packed {
    logic [2:0][DW-1:0]     u;
    logic [2:0][DW-1:0]     v;
    logic [2:0][DW-1:0]     w;
    logic [QW-1:0]          t;
  } end_t;

  logic                   en;
  logic [LIMIT_W-1:0]     limit_r;
  logic signed [CW-1:0]   pt [N_PTS];

  // front end
  logic                   vld_f;
  logic signed [DOTW-1:0] a_f, b_f, c_f, d_f, e_f;
  logic [2:0][DW-1:0]     u_f, v_f, w_f;
  geo_t                   geo_f, geo_m, geo_p_r, geo_s1, geo_bs;

  // s from the full system
  logic                   vld_m, vld_p_r, vld_s1, vld_bs;
  logic signed [WPW-1:0]  ac_m, bb_m, be_m, cd_m;
  logic signed [NW-1:0]   den_nxt, num_nxt, den_p_r, num_p_r;
  logic                   par_nxt;
  logic [QW-1:0]          s1;

  // t from s
  logic signed [BSW-1:0]  bs_m;
  logic signed [TW-1:0]   numt_r, dent_r;
  tst_t                   tst_r, tst_t2;
  logic                   vld_t_r, vld_t2;
  logic [QW-1:0]          t2;

  // s again from t
  logic signed [BSW-1:0]  bt_m;
  fin_t                   fin_in, fin_bt;
  logic                   vld_bt, vld_s_r, vld_s2;
  logic signed [TW-1:0]   nums2_r, dens2_r;
  end_t                   end_r, end_s2;
  logic [QW-1:0]          s2;

  // distance
  logic signed [DW+SW-1:0] us_r [3];
  logic signed [DW+SW-1:0] vt_r [3];
  logic [2:0][DW-1:0]      w_x1_r;
  logic signed [XW-1:0]    diff_r [3];
  logic signed [2*XW-1:0]  sq [3];
  logic signed [SQW-1:0]   sum_r, lim_ext;
  logic                    vld_x1_r, vld_x2_r, vld_q1_r, vld_q2_r, vld_x4_r;
  logic                    out_valid_r, contact_r;

  // hold the whole pipe only while a result waits
  assign en           = !out_valid_r || out_res.ready;
  assign in_seg.ready = en;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  assign pt[0]  = in_seg.a_start_x;
  assign pt[1]  = in_seg.a_start_y;
  assign pt[2]  = in_seg.a_start_z;
  assign pt[3]  = in_seg.a_end_x;
  assign pt[4]  = in_seg.a_end_y;
  assign pt[5]  = in_seg.a_end_z;
  assign pt[6]  = in_seg.b_start_x;
  assign pt[7]  = in_seg.b_start_y;
  assign pt[8]  = in_seg.b_start_z;
  assign pt[9]  = in_seg.b_end_x;
  assign pt[10] = in_seg.b_end_y;
  assign pt[11] = in_seg.b_end_z;

  sstc_dots #(.CW(CW)) u_dots (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_in(in_seg.valid && in_seg.ready), .pt(pt),
    .vld_out(vld_f), .a(a_f), .b(b_f), .c(c_f), .d(d_f), .e(e_f),
    .u(u_f), .v(v_f), .w(w_f)
  );

  assign geo_f = {a_f, b_f, c_f, d_f, e_f, u_f, v_f, w_f};

  // products for the denominator and the first numerator
  sstc_mul #(.AW(DOTW), .BW(DOTW)) u_mul_ac (.clk(clk), .en(en), .a(a_f), .b(c_f), .p(ac_m));
  sstc_mul #(.AW(DOTW), .BW(DOTW)) u_mul_bb (.clk(clk), .en(en), .a(b_f), .b(b_f), .p(bb_m));
  sstc_mul #(.AW(DOTW), .BW(DOTW)) u_mul_be (.clk(clk), .en(en), .a(b_f), .b(e_f), .p(be_m));
  sstc_mul #(.AW(DOTW), .BW(DOTW)) u_mul_cd (.clk(clk), .en(en), .a(c_f), .b(d_f), .p(cd_m));

  sstc_dly #(.PLW($bits(geo_t))) u_dly_m (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld_f), .pl_in(geo_f),
    .out_vld(vld_m), .pl_out(geo_m)
  );

  // near-parallel pairs start from s = 0
  assign den_nxt = NW'(ac_m) - NW'(bb_m);
  assign num_nxt = NW'(be_m) - NW'(cd_m);
  assign par_nxt = !($signed(EPW'(den_nxt)) > $signed(EPS));

  always_ff @(posedge clk) begin
    if (en) begin
      den_p_r <= den_nxt;
      num_p_r <= par_nxt ? '0 : num_nxt;
      geo_p_r <= geo_m;
    end
  end

  sstc_div #(.W(NW), .QB(PB), .PLW($bits(geo_t))) u_div_s1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld_p_r),
    .n(num_p_r), .d(den_p_r), .pl_in(geo_p_r),
    .out_vld(vld_s1), .q(s1), .pl_out(geo_s1)
  );

  // t = clamp((b*s + e) / c)
  sstc_mul #(.AW(DOTW), .BW(SW)) u_mul_bs (
    .clk(clk), .en(en), .a(geo_s1.b), .b($signed({1'b0, s1})), .p(bs_m)
  );

  sstc_dly #(.PLW($bits(geo_t))) u_dly_bs (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld_s1), .pl_in(geo_s1),
    .out_vld(vld_bs), .pl_out(geo_bs)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      numt_r <= TW'(bs_m) + (TW'(geo_bs.e) <<< PB);
      dent_r <= TW'(geo_bs.c) <<< PB;
      tst_r  <= {geo_bs.a, geo_bs.b, geo_bs.d, geo_bs.u, geo_bs.v, geo_bs.w};
    end
  end

  sstc_div #(.W(TW), .QB(PB), .PLW($bits(tst_t))) u_div_t (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld_t_r),
    .n(numt_r), .d(dent_r), .pl_in(tst_r),
    .out_vld(vld_t2), .q(t2), .pl_out(tst_t2)
  );

  // s = clamp((b*t - d) / a)
  sstc_mul #(.AW(DOTW), .BW(SW)) u_mul_bt (
    .clk(clk), .en(en), .a(tst_t2.b), .b($signed({1'b0, t2})), .p(bt_m)
  );

  assign fin_in = {tst_t2.a, tst_t2.d, tst_t2.u, tst_t2.v, tst_t2.w, t2};

  sstc_dly #(.PLW($bits(fin_t))) u_dly_bt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld_t2), .pl_in(fin_in),
    .out_vld(vld_bt), .pl_out(fin_bt)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      nums2_r <= TW'(bt_m) - (TW'(fin_bt.d) <<< PB);
      dens2_r <= TW'(fin_bt.a) <<< PB;
      end_r   <= {fin_bt.u, fin_bt.v, fin_bt.w, fin_bt.t};
    end
  end

  sstc_div #(.W(TW), .QB(PB), .PLW($bits(end_t))) u_div_s2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld_s_r),
    .n(nums2_r), .d(dens2_r), .pl_in(end_r),
    .out_vld(vld_s2), .q(s2), .pl_out(end_s2)
  );

  // closest-point difference w + s*u - t*v, scaled by 2^PB
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        us_r[k]   <= $signed(end_s2.u[k]) * $signed({1'b0, s2});
        vt_r[k]   <= $signed(end_s2.v[k]) * $signed({1'b0, end_s2.t});
        diff_r[k] <= (XW'($signed(w_x1_r[k])) <<< PB) + XW'(us_r[k]) - XW'(vt_r[k]);
      end
      w_x1_r <= end_s2.w;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sq
    sstc_mul #(.AW(XW), .BW(XW)) u_mul_sq (
      .clk(clk), .en(en), .a(diff_r[k]), .b(diff_r[k]), .p(sq[k])
    );
  end

  // sum the squares, then compare against the scaled limit
  assign lim_ext = $signed(SQW'(limit_r) << (2 * PB));

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r     <= SQW'(sq[0]) + SQW'(sq[1]) + SQW'(sq[2]);
      contact_r <= (sum_r <= lim_ext);
    end
  end

  // advance valid bits between the units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p_r     <= 1'b0;
      vld_t_r     <= 1'b0;
      vld_s_r     <= 1'b0;
      vld_x1_r    <= 1'b0;
      vld_x2_r    <= 1'b0;
      vld_q1_r    <= 1'b0;
      vld_q2_r    <= 1'b0;
      vld_x4_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_p_r     <= vld_m;
      vld_t_r     <= vld_bs;
      vld_s_r     <= vld_bt;
      vld_x1_r    <= vld_s2;
      vld_x2_r    <= vld_x1_r;
      vld_q1_r    <= vld_x2_r;
      vld_q2_r    <= vld_q1_r;
      vld_x4_r    <= vld_q2_r;
      out_valid_r <= vld_x4_r;
    end
  end

  assign out_res.valid   = out_valid_r;
  assign out_res.contact = contact_r;
endmodule

@@ design/sstc_chk.sv @@
// Port-level checker for the segment contact test, bound to the top level
`include "segment_segment_contact_test_defines.svh"

module sstc_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic contact
);
  // no result survives reset
  `SSTC_ASSERT_ALWAYS(a_rst_clears, clk, !rst_n, !out_valid, "result valid after reset")

  // input is stalled only by a waiting result
  `SSTC_ASSERT_SAME(a_in_ready, clk, rst_n, !out_valid || out_ready, in_ready, "input stalled without output backpressure")

  // stalled result keeps valid and value
  `SSTC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SSTC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(contact), "result changed while stalled")
endmodule

bind segment_segment_contact_test sstc_chk u_sstc_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_seg.valid),
  .in_ready(in_seg.ready),
  .out_valid(out_res.valid),
  .out_ready(out_res.ready),
  .contact(out_res.contact)
);
